@@ design/ish_pkg.sv @@
package ish_pkg;

  // Default histogram shape
  localparam int unsigned BIN_WIDTH_DEF = 100;
  localparam int unsigned TOP_BIN_DEF   = 150;

  // Fixed field widths
  localparam int SIZE_W  = 32;
  localparam int BIN_W   = 8;
  localparam int COUNT_W = 32;

  // Item kinds
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;      // latch the incoming item
    logic prep;      // form magnitude, test clamp, multiply by the reciprocal
    logic div_step;  // take the bin index from the reciprocal product
    logic fetch;     // read the addressed bin
    logic finish;    // update store and load the result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_read;
    logic pass;
    logic clamp;
  } status_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

endpackage

@@ design/insert_size_histogram.sv @@
// Insert-size histogram for read pairs. Each transfer on the input is either an
// alignment record (kind 0) or a readout of one bin (kind 1), and each gives exactly
// one result transfer. A record is counted only when paired, first mate, mapped
// and mate mapped all hold; its bin is |insert_size| / BIN_WIDTH, clamped to the
// overflow bin TOP_BIN, and both that bin and the pair total saturate at all ones.
// A readout past TOP_BIN returns zero. One item is in flight at a time: a readout
// or a clamped record goes through prepare, fetch and finish, a filtered record
// skips fetch, and any other counted record adds a divide step that takes the bin
// index from a multiply by a fixed reciprocal of BIN_WIDTH; the bin store is a
// single port memory, so each count is a read then a write. Counters come out of
// reset at zero through per-bin valid flags, so no clearing pass is needed. The
// result sits in an output register, so the next item is taken while a result waits.
module insert_size_histogram #(
  parameter int unsigned BIN_WIDTH = ish_pkg::BIN_WIDTH_DEF,
  parameter int unsigned TOP_BIN   = ish_pkg::TOP_BIN_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // item channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic                              paired,
  input  logic                              first_mate,
  input  logic                              mapped,
  input  logic                              mate_mapped,
  input  logic signed [ish_pkg::SIZE_W-1:0] insert_size,
  input  logic [ish_pkg::BIN_W-1:0]         read_bin,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              counted,
  output logic [ish_pkg::BIN_W-1:0]         bin_hit,
  output logic [ish_pkg::COUNT_W-1:0]       count_value,
  output logic [ish_pkg::COUNT_W-1:0]       pairs_seen
);

  ish_pkg::cmd_t    cmd;
  ish_pkg::status_t sts;

  // Sequencer: take, prepare, divide and fetch as the item needs, then finish once
  // the result register is free.
  ish_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath: flag filter, magnitude, divider, bin store, totals and result register.
  ish_dp #(
    .BIN_WIDTH (BIN_WIDTH),
    .TOP_BIN   (TOP_BIN)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .kind        (kind),
    .paired      (paired),
    .first_mate  (first_mate),
    .mapped      (mapped),
    .mate_mapped (mate_mapped),
    .insert_size (insert_size),
    .read_bin    (read_bin),
    .counted     (counted),
    .bin_hit     (bin_hit),
    .count_value (count_value),
    .pairs_seen  (pairs_seen)
  );

  // Hold off further items once one has been taken.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item taken while previous one still in progress");

  // Never overwrite a result that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || !out_stall))
    else $error("result register loaded while holding an untaken result");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bin_hit <= ish_pkg::BIN_W'(TOP_BIN)))
    else $error("bin index beyond overflow bin");

  // A counted record reports no readout value and a non-zero total.
  a_counted_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && counted) |-> (count_value == '0 && pairs_seen != '0))
    else $error("inconsistent result for a counted record");

endmodule

@@ design/ish_ctrl.sv @@
module ish_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output ish_pkg::cmd_t     cmd,
  input  ish_pkg::status_t  sts
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PREP   = 5'b00010,
    S_DIV    = 5'b00100,
    S_FETCH  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   ovld, ovld_next;
  logic   out_free;

  assign out_free  = !ovld || !out_stall;
  assign in_stall  = (state != S_IDLE);
  assign out_valid = ovld;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid) state_next = S_PREP;
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        if (sts.is_read)    state_next = S_FETCH;
        else if (!sts.pass) state_next = S_FINISH;
        else if (sts.clamp) state_next = S_FETCH;
        else                state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        state_next   = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ovld_next = ovld;
    if (cmd.finish)      ovld_next = 1'b1;
    else if (!out_stall) ovld_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ovld  <= 1'b0;
    end else begin
      state <= state_next;
      ovld  <= ovld_next;
    end
  end

endmodule

@@ design/ish_dp.sv @@
module ish_dp #(
  parameter int unsigned BIN_WIDTH = ish_pkg::BIN_WIDTH_DEF,
  parameter int unsigned TOP_BIN   = ish_pkg::TOP_BIN_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ish_pkg::cmd_t                     cmd,
  output ish_pkg::status_t                  sts,
  input  logic                              kind,
  input  logic                              paired,
  input  logic                              first_mate,
  input  logic                              mapped,
  input  logic                              mate_mapped,
  input  logic signed [ish_pkg::SIZE_W-1:0] insert_size,
  input  logic [ish_pkg::BIN_W-1:0]         read_bin,
  output logic                              counted,
  output logic [ish_pkg::BIN_W-1:0]         bin_hit,
  output logic [ish_pkg::COUNT_W-1:0]       count_value,
  output logic [ish_pkg::COUNT_W-1:0]       pairs_seen
);

  localparam int unsigned AW    = $clog2(TOP_BIN + 1);
  localparam int unsigned LIMIT = TOP_BIN * BIN_WIDTH;
  localparam int unsigned RW    = $clog2(LIMIT + 1);
  localparam int unsigned LW    = $clog2(BIN_WIDTH);
  localparam int unsigned SH    = RW + LW;
  localparam int unsigned MW    = RW + 1;
  localparam int unsigned PW    = RW + MW;
  // ceil(2^SH / BIN_WIDTH) gives the exact quotient for every magnitude below 2^RW
  localparam longint unsigned RECIP_L = ((64'd1 << SH) + BIN_WIDTH - 1) / BIN_WIDTH;

  localparam logic [ish_pkg::SIZE_W-1:0] LIMIT_V = ish_pkg::SIZE_W'(LIMIT);
  localparam logic [MW-1:0]              RECIP   = MW'(RECIP_L);
  localparam logic [AW-1:0]              TOP_IDX = AW'(TOP_BIN);

  // latched item
  logic                        kind_q;
  logic                        pass_q;
  logic                        oob_q;
  logic [ish_pkg::SIZE_W-1:0]  size_q;

  // division by the bin width
  logic [ish_pkg::SIZE_W-1:0]  mag;
  logic [PW-1:0]               prod;

  // store
  logic [ish_pkg::COUNT_W-1:0] mem [0:TOP_BIN];
  logic [TOP_BIN:0]            vld;
  logic [AW-1:0]               addr;
  logic [ish_pkg::COUNT_W-1:0] rd_data;
  logic                        rd_vld;
  logic [ish_pkg::COUNT_W-1:0] pair_total;

  logic [ish_pkg::COUNT_W-1:0] cur;
  logic [ish_pkg::COUNT_W-1:0] cur_inc;
  logic [ish_pkg::COUNT_W-1:0] pt_inc;
  logic                        rec;

  assign mag = size_q[ish_pkg::SIZE_W-1] ? (~size_q + 1'b1) : size_q;

  assign sts.is_read  = (kind_q == ish_pkg::KIND_READ);
  assign sts.pass     = pass_q;
  assign sts.clamp    = (mag >= LIMIT_V);

  assign rec     = (kind_q == ish_pkg::KIND_RECORD) && pass_q;
  assign cur     = rd_vld ? rd_data : '0;
  assign cur_inc = ish_pkg::sat_inc(cur);
  assign pt_inc  = ish_pkg::sat_inc(pair_total);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind_q <= kind;
      pass_q <= paired & first_mate & mapped & mate_mapped;
      oob_q  <= (read_bin > ish_pkg::BIN_W'(TOP_BIN));
      size_q <= insert_size;
    end
  end

  // bin address: readout index, overflow bin, or the scaled quotient
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      addr <= read_bin[AW-1:0];
    end else if (cmd.prep && !sts.is_read && sts.clamp) begin
      addr <= TOP_IDX;
    end else if (cmd.div_step) begin
      addr <= prod[SH +: AW];
    end
  end

  // multiply by the fixed reciprocal; the quotient sits from bit SH upward
  always_ff @(posedge clk) begin
    if (cmd.prep) prod <= mag[RW-1:0] * RECIP;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && rec) mem[addr] <= cur_inc;
    if (cmd.fetch) begin
      rd_data <= mem[addr];
      rd_vld  <= vld[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      pair_total <= '0;
    end else if (cmd.finish && rec) begin
      vld[addr]  <= 1'b1;
      pair_total <= pt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      counted     <= rec;
      bin_hit     <= rec ? ish_pkg::BIN_W'(addr) : '0;
      count_value <= (sts.is_read && !oob_q) ? cur : '0;
      pairs_seen  <= rec ? pt_inc : pair_total;
    end
  end

endmodule

@@ verif/tb_top.sv @@
module tb_top;

  // Shape of the block under test: the defaults of the package
  localparam int unsigned BIN_WIDTH = ish_pkg::BIN_WIDTH_DEF;
  localparam int unsigned TOP_BIN   = ish_pkg::TOP_BIN_DEF;
  localparam logic [ish_pkg::BIN_W-1:0] TOP_IDX = ish_pkg::BIN_W'(TOP_BIN);

  // Run length and guards
  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned DRAIN_CYCLES = 40;      // the longest item also takes a divide step
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // Directed rows either carry a typed-in reply or lean on the predictor
  localparam logic TYPED     = 1'b1;
  localparam logic PREDICTED = 1'b0;

  typedef struct packed {
    logic                         kind;
    logic                         paired;
    logic                         first_mate;
    logic                         mapped;
    logic                         mate_mapped;
    logic [ish_pkg::SIZE_W-1:0]   insert_size;
    logic [ish_pkg::BIN_W-1:0]    read_bin;
  } record_t;

  typedef struct packed {
    logic                         counted;
    logic [ish_pkg::BIN_W-1:0]    bin_hit;
    logic [ish_pkg::COUNT_W-1:0]  count_value;
    logic [ish_pkg::COUNT_W-1:0]  pairs_seen;
  } reply_t;

  typedef struct packed {
    record_t rec;
    logic    typed;
    reply_t  want;
  } stim_row_t;

  // Receiver behaviour: each mode holds for a random stretch of cycles
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HALF,
    STALL_HEAVY
  } stall_mode_e;

  logic                         clk;
  logic                         rst         = 1'b1;
  logic                         in_valid    = 1'b0;
  logic                         in_stall;
  logic                         kind        = ish_pkg::KIND_RECORD;
  logic                         paired      = 1'b0;
  logic                         first_mate  = 1'b0;
  logic                         mapped      = 1'b0;
  logic                         mate_mapped = 1'b0;
  logic [ish_pkg::SIZE_W-1:0]   insert_size = '0;
  logic [ish_pkg::BIN_W-1:0]    read_bin    = '0;
  logic                         out_valid;
  logic                         out_stall   = 1'b0;
  logic                         counted;
  logic [ish_pkg::BIN_W-1:0]    bin_hit;
  logic [ish_pkg::COUNT_W-1:0]  count_value;
  logic [ish_pkg::COUNT_W-1:0]  pairs_seen;

  // Predictor state: our own copy of the histogram and the pair total
  logic [ish_pkg::COUNT_W-1:0]  bin_tally [0:TOP_BIN];
  logic [ish_pkg::COUNT_W-1:0]  pair_tally;

  // Replies still owed by the block, oldest first
  reply_t              histogram_replies [$];
  stim_row_t           directed_rows [$];

  int unsigned         mismatches  = 0;
  int unsigned         burst_left  = 0;
  int unsigned         cycle_count = 0;
  stall_mode_e         stall_mode  = STALL_NONE;
  int unsigned         mode_left   = 0;

  insert_size_histogram dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .paired      (paired),
    .first_mate  (first_mate),
    .mapped      (mapped),
    .mate_mapped (mate_mapped),
    .insert_size (insert_size),
    .read_bin    (read_bin),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .counted     (counted),
    .bin_hit     (bin_hit),
    .count_value (count_value),
    .pairs_seen  (pairs_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one accepted item to the histogram copy and return the reply it
  // should produce. Readouts and filtered records leave the state alone.
  function automatic reply_t histogram_update(input record_t rec);
    reply_t                      r;
    logic [ish_pkg::SIZE_W-1:0]  magnitude;
    logic [ish_pkg::SIZE_W-1:0]  slot;
    r = '0;
    if (rec.kind == ish_pkg::KIND_READ) begin
      // an index past the overflow bin reads as zero
      if (rec.read_bin <= TOP_BIN)
        r.count_value = bin_tally[rec.read_bin];
    end else if (rec.paired && rec.first_mate && rec.mapped && rec.mate_mapped) begin
      // the most negative size has magnitude 2^31, still fine as unsigned
      magnitude = rec.insert_size[ish_pkg::SIZE_W-1] ? (~rec.insert_size + 1'b1)
                                                     : rec.insert_size;
      slot = magnitude / BIN_WIDTH;
      if (slot > TOP_BIN)
        slot = TOP_BIN;
      // both counters stick at all ones
      if (bin_tally[slot] != '1)
        bin_tally[slot] = bin_tally[slot] + 1'b1;
      if (pair_tally != '1)
        pair_tally = pair_tally + 1'b1;
      r.counted = 1'b1;
      r.bin_hit = slot[ish_pkg::BIN_W-1:0];
    end
    r.pairs_seen = pair_tally;
    return r;
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [ish_pkg::COUNT_W-1:0] want,
                                 input logic [ish_pkg::COUNT_W-1:0] got);
    $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_count, what, want, got);
    mismatches++;
  endtask

  task automatic add_row(input logic k, input logic p, input logic f, input logic m,
                         input logic mm, input logic [ish_pkg::SIZE_W-1:0] size,
                         input logic [ish_pkg::BIN_W-1:0] rbin, input logic typed,
                         input logic c, input logic [ish_pkg::BIN_W-1:0] b,
                         input logic [ish_pkg::COUNT_W-1:0] v,
                         input logic [ish_pkg::COUNT_W-1:0] ps);
    stim_row_t row;
    row.rec   = '{k, p, f, m, mm, size, rbin};
    row.typed = typed;
    row.want  = '{c, b, v, ps};
    directed_rows.push_back(row);
  endtask

  // Random item: mostly well-formed first-mate records with varied sizes,
  // then readouts, then records with random flags as noise.
  function automatic record_t random_record();
    record_t                     rec;
    int unsigned                 pick;
    int unsigned                 shape;
    logic [ish_pkg::SIZE_W-1:0]  magnitude;
    pick  = $urandom_range(0, 99);
    shape = $urandom_range(0, 99);
    rec.kind        = ish_pkg::KIND_RECORD;
    rec.paired      = 1'b1;
    rec.first_mate  = 1'b1;
    rec.mapped      = 1'b1;
    rec.mate_mapped = 1'b1;
    rec.insert_size = $urandom;
    rec.read_bin    = ish_pkg::BIN_W'($urandom_range(0, 255));
    if (pick < 15) begin
      rec.kind = ish_pkg::KIND_READ;
      {rec.paired, rec.first_mate, rec.mapped, rec.mate_mapped} = 4'($urandom_range(0, 15));
      // keep most readouts inside the store, some past the top
      if ($urandom_range(0, 3) != 0)
        rec.read_bin = ish_pkg::BIN_W'($urandom_range(0, TOP_BIN));
    end else if (pick < 27) begin
      {rec.paired, rec.first_mate, rec.mapped, rec.mate_mapped} = 4'($urandom_range(0, 15));
    end else begin
      if (shape < 50)
        magnitude = $urandom_range(0, 16000);
      else if (shape < 70)
        // straddle a bin edge: one below, on, or one above
        magnitude = $urandom_range(0, TOP_BIN + 1) * BIN_WIDTH + $urandom_range(0, 2) - 1;
      else
        magnitude = '0;
      if (shape < 70)
        rec.insert_size = $urandom_range(0, 1) ? -magnitude : magnitude;
      else if (shape >= 90)
        case ($urandom_range(0, 4))
          0:       rec.insert_size = 32'h0000_0000;
          1:       rec.insert_size = 32'h7FFF_FFFF;
          2:       rec.insert_size = 32'h8000_0000;
          3:       rec.insert_size = 32'h8000_0001;
          default: rec.insert_size = 32'hFFFF_FFFF;
        endcase
    end
    return rec;
  endfunction

  // Offer one item and hold it until the transfer happens. Gaps between
  // bursts are inserted before the item, so the step that ends a transfer
  // never sees valid both dropped and raised.
  task automatic offer_record(input record_t rec, input logic typed, input reply_t want);
    int unsigned gap;
    reply_t      predicted;
    if (burst_left == 0) begin
      // a quarter of bursts follow straight on, the rest leave a gap
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    kind        <= rec.kind;
    paired      <= rec.paired;
    first_mate  <= rec.first_mate;
    mapped      <= rec.mapped;
    mate_mapped <= rec.mate_mapped;
    insert_size <= rec.insert_size;
    read_bin    <= rec.read_bin;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    // transfer taken at this edge: advance the predictor in acceptance order
    predicted = histogram_update(rec);
    histogram_replies.push_back(typed ? want : predicted);
  endtask

  // Receiver: stall on a pattern of its own, switching mode every so often,
  // including stretches with no stall at all.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_mode <= STALL_NONE;
      mode_left  <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 3));
        mode_left  <= $urandom_range(10, 150);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HALF:  out_stall <= 1'($urandom_range(0, 1));
        default:     out_stall <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Result checker: every transfer out is matched against the oldest reply
  // still owed, field by field.
  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (histogram_replies.size() == 0) begin
        report_mismatch("result with nothing owed, pairs_seen", '0, pairs_seen);
      end else begin
        want = histogram_replies.pop_front();
        if (counted !== want.counted)
          report_mismatch("counted", ish_pkg::COUNT_W'(want.counted),
                          ish_pkg::COUNT_W'(counted));
        if (bin_hit !== want.bin_hit)
          report_mismatch("bin_hit", ish_pkg::COUNT_W'(want.bin_hit),
                          ish_pkg::COUNT_W'(bin_hit));
        if (count_value !== want.count_value)
          report_mismatch("count_value", want.count_value, count_value);
        if (pairs_seen !== want.pairs_seen)
          report_mismatch("pairs_seen", want.pairs_seen, pairs_seen);
      end
    end
  end

  // Watchdog: drop the run if it hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL insert_size_histogram");
    $finish;
  end

  initial begin
    for (int i = 0; i <= TOP_BIN; i++)
      bin_tally[i] = '0;
    pair_tally = '0;

    // Directed table. Typed replies are the ones readable at a glance:
    // an empty store, the size extremes and the filter cases.
    add_row(ish_pkg::KIND_READ,   0, 0, 0, 0, 32'h0000_0000, 8'd0,   TYPED, 0, 0,       0, 0);
    add_row(ish_pkg::KIND_READ,   1, 1, 1, 1, 32'hFFFF_FFFF, 8'd255, TYPED, 0, 0,       0, 0);
    add_row(ish_pkg::KIND_RECORD, 1, 1, 1, 1, 32'h0000_0000, 8'd0,   TYPED, 1, 0,       0, 1);
    add_row(ish_pkg::KIND_RECORD, 1, 1, 1, 1, 32'h7FFF_FFFF, 8'd0,   TYPED, 1, TOP_IDX, 0, 2);
    add_row(ish_pkg::KIND_RECORD, 1, 1, 1, 1, 32'h8000_0000, 8'd255, TYPED, 1, TOP_IDX, 0, 3);
    // each flag missing in turn, then all of them
    add_row(ish_pkg::KIND_RECORD, 0, 1, 1, 1, 32'd500,       8'd0,   TYPED, 0, 0,       0, 3);
    add_row(ish_pkg::KIND_RECORD, 1, 0, 1, 1, 32'd500,       8'd0,   TYPED, 0, 0,       0, 3);
    add_row(ish_pkg::KIND_RECORD, 1, 1, 0, 1, 32'd500,       8'd0,   TYPED, 0, 0,       0, 3);
    add_row(ish_pkg::KIND_RECORD, 1, 1, 1, 0, 32'd500,       8'd0,   TYPED, 0, 0,       0, 3);
    add_row(ish_pkg::KIND_RECORD, 0, 0, 0, 0, 32'hFFFF_FFFF, 8'd255, TYPED, 0, 0,       0, 3);
    add_row(ish_pkg::KIND_RECORD, 1, 1, 1, 1, 32'hFFFF_FFFF, 8'd0,   TYPED, 1, 0,       0, 4);
    // readouts ignore flags and size
    add_row(ish_pkg::KIND_READ,   1, 1, 1, 1, 32'h8000_0000, 8'd0,   TYPED, 0, 0,       2, 4);
    add_row(ish_pkg::KIND_READ,   0, 0, 0, 0, 32'h7FFF_FFFF, TOP_IDX, TYPED, 0, 0,      2, 4);
    // bin edges and the clamp boundary, then readouts up to one past the top bin
    add_row(ish_pkg::KIND_RECORD, 1, 1, 1, 1, 32'd99,        8'd0, PREDICTED, 0, 0, 0, 0);
    add_row(ish_pkg::KIND_RECORD, 1, 1, 1, 1, 32'd100,       8'd0, PREDICTED, 0, 0, 0, 0);
    add_row(ish_pkg::KIND_RECORD, 1, 1, 1, 1, -32'sd100,     8'd0, PREDICTED, 0, 0, 0, 0);
    add_row(ish_pkg::KIND_RECORD, 1, 1, 1, 1, 32'd14999,     8'd0, PREDICTED, 0, 0, 0, 0);
    add_row(ish_pkg::KIND_RECORD, 1, 1, 1, 1, 32'd15000,     8'd0, PREDICTED, 0, 0, 0, 0);
    add_row(ish_pkg::KIND_RECORD, 1, 1, 1, 1, -32'sd15099,   8'd0, PREDICTED, 0, 0, 0, 0);
    add_row(ish_pkg::KIND_RECORD, 1, 1, 1, 1, 32'd15100,     8'd0, PREDICTED, 0, 0, 0, 0);
    add_row(ish_pkg::KIND_RECORD, 1, 1, 1, 1, 32'h8000_0001, 8'd0, PREDICTED, 0, 0, 0, 0);
    add_row(ish_pkg::KIND_READ,   0, 0, 0, 0, 32'd0, TOP_IDX + 8'd1, PREDICTED, 0, 0, 0, 0);
    add_row(ish_pkg::KIND_READ,   0, 0, 0, 0, 32'd0, 8'd1,           PREDICTED, 0, 0, 0, 0);
    add_row(ish_pkg::KIND_READ,   0, 0, 0, 0, 32'd0, TOP_IDX - 8'd1, PREDICTED, 0, 0, 0, 0);
    add_row(ish_pkg::KIND_READ,   0, 0, 0, 0, 32'd0, TOP_IDX,        PREDICTED, 0, 0, 0, 0);

    // hold reset at the start, then release it
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      offer_record(directed_rows[i].rec, directed_rows[i].typed, directed_rows[i].want);

    for (int n = 0; n < RANDOM_ITEMS; n++)
      offer_record(random_record(), PREDICTED, '0);

    // drain: wait for every owed reply, then watch for strays
    in_valid <= 1'b0;
    while (histogram_replies.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("PASS insert_size_histogram");
    else
      $display("FAIL insert_size_histogram");
    $finish;
  end

endmodule
